/* design/vlt_pkg.sv */
// vlt_pkg: shared types, constants and helpers of the 3-D vector transform.
// Depends on nothing; used by vlt_cordic and vector_linear_3d_transform.
package vlt_pkg;

  localparam int FracBits = 16;
  localparam int DataW    = 32;
  localparam int ProdW    = 2 * DataW;
  localparam int FmW      = ProdW - FracBits;
  localparam int SatW     = FmW + 2;

  localparam int CordicSteps  = 30;
  localparam int CordicPerStg = 3;
  localparam int CordicStages = CordicSteps / CordicPerStg;
  localparam int CordicShift  = 30 - FracBits;
  localparam int ZW           = 36;
  localparam int CW           = 34;

  localparam logic signed [ZW-1:0] Q30K      = 36'sd652032874;
  localparam logic signed [ZW-1:0] Q30Pi     = 36'sd3373259426;
  localparam logic signed [ZW-1:0] Q30HalfPi = 36'sd1686629713;
  localparam logic signed [ZW-1:0] Q30TwoPi  = 36'sd6746518852;

  localparam logic [31:0] AtanQ30 [CordicSteps] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
  };

  localparam logic [2:0] OP_ROTATE   = 3'd0;
  localparam logic [2:0] OP_SCALE    = 3'd1;
  localparam logic [2:0] OP_PROJECT  = 3'd2;
  localparam logic [2:0] OP_REFL_AX  = 3'd3;
  localparam logic [2:0] OP_REFL_PL  = 3'd4;
  localparam logic [2:0] OP_SHEAR    = 3'd5;

  localparam logic [1:0] AXIS_NONE = 2'd0;
  localparam logic [1:0] AXIS_X    = 2'd1;
  localparam logic [1:0] AXIS_Y    = 2'd2;
  localparam logic [1:0] AXIS_Z    = 2'd3;

  localparam logic signed [DataW-1:0] OneQ = 32'sd1 <<< FracBits;
  localparam logic signed [SatW-1:0]  SatHi = 50'sd2147483647;
  localparam logic signed [SatW-1:0]  SatLo = -50'sd2147483648;

  typedef struct packed {
    logic [2:0]             opcode;
    logic [1:0]             axis;
    logic [2:0][DataW-1:0]  vec;
    logic [2:0][DataW-1:0]  par;
    logic [2:0][DataW-1:0]  lhs;
  } item_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [SatW-1:0] v);
    logic signed [DataW-1:0] r;
    if (v > SatHi) begin
      r = SatHi[DataW-1:0];
    end else if (v < SatLo) begin
      r = SatLo[DataW-1:0];
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

/* design/vlt_cordic.sv */
// vlt_cordic: rotation-mode CORDIC, three micro-rotations per register stage.
// Depends on vlt_pkg; carries the item and its valid bit alongside.
module vlt_cordic (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  vlt_pkg::item_t               item_i,
  input  logic signed [vlt_pkg::CW-1:0] z_i,
  input  logic                         flip_i,
  output logic                         valid_o,
  output vlt_pkg::item_t               item_o,
  output logic signed [vlt_pkg::CW-1:0] x_o,
  output logic signed [vlt_pkg::CW-1:0] y_o,
  output logic                         flip_o
);

  localparam int NStg = vlt_pkg::CordicStages;
  localparam int W    = vlt_pkg::CW;

  logic                vld_q  [NStg];
  vlt_pkg::item_t      item_q [NStg];
  logic signed [W-1:0] x_q    [NStg];
  logic signed [W-1:0] y_q    [NStg];
  logic signed [W-1:0] z_q    [NStg];
  logic                flip_q [NStg];

  for (genvar g = 0; g < NStg; g++) begin : g_stg
    logic signed [W-1:0] x_in, y_in, z_in;
    logic signed [W-1:0] x_d, y_d, z_d;
    logic                vld_in, flip_in;
    vlt_pkg::item_t      item_in;

    if (g == 0) begin : g_first
      assign x_in    = W'(vlt_pkg::Q30K);
      assign y_in    = '0;
      assign z_in    = z_i;
      assign vld_in  = valid_i;
      assign flip_in = flip_i;
      assign item_in = item_i;
    end else begin : g_next
      assign x_in    = x_q[g-1];
      assign y_in    = y_q[g-1];
      assign z_in    = z_q[g-1];
      assign vld_in  = vld_q[g-1];
      assign flip_in = flip_q[g-1];
      assign item_in = item_q[g-1];
    end

    always_comb begin
      logic signed [W-1:0] xs, ys, zs, xn, at;
      xs = x_in;
      ys = y_in;
      zs = z_in;
      for (int k = 0; k < vlt_pkg::CordicPerStg; k++) begin
        at = W'(signed'({2'b00, vlt_pkg::AtanQ30[g*vlt_pkg::CordicPerStg + k]}));
        if (zs >= 0) begin
          xn = xs - (ys >>> (g*vlt_pkg::CordicPerStg + k));
          ys = ys + (xs >>> (g*vlt_pkg::CordicPerStg + k));
          zs = zs - at;
        end else begin
          xn = xs + (ys >>> (g*vlt_pkg::CordicPerStg + k));
          ys = ys - (xs >>> (g*vlt_pkg::CordicPerStg + k));
          zs = zs + at;
        end
        xs = xn;
      end
      x_d = xs;
      y_d = ys;
      z_d = zs;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[g]    <= x_d;
        y_q[g]    <= y_d;
        z_q[g]    <= z_d;
        flip_q[g] <= flip_in;
        item_q[g] <= item_in;
      end
    end
  end

  assign valid_o = vld_q[NStg-1];
  assign item_o  = item_q[NStg-1];
  assign x_o     = x_q[NStg-1];
  assign y_o     = y_q[NStg-1];
  assign flip_o  = flip_q[NStg-1];

endmodule

/* design/vector_linear_3d_transform.sv */
// vector_linear_3d_transform: row vector times a 3x3 rotate/scale/project/
// reflect/shear matrix, Q15.16, saturating. Depends on vlt_pkg, vlt_cordic.
//
//  channel  dir  tdata (low bit up)                             tuser
//  s_axis   in   vec_x vec_y vec_z par_x par_y par_z angle, pad  opcode axis
//  m_axis   out  out_x out_y out_z                              bad_axis
//
// One beat in and one beat out per cycle while the output is not stalled; stages:
// input register, two angle-reduction stages, ten CORDIC stages, matrix product and matrix
// assembly stages, vector product and sum stages.
// rst_ni clears the valid bits only. One enable moves every stage; it holds
// while the output beat waits, so nothing is lost or repeated.
module vector_linear_3d_transform (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [215:0] s_axis_tdata_i,  // vec_x vec_y vec_z par_x par_y par_z angle, zero pad
  input  logic [4:0]   s_axis_tuser_i,  // opcode[2:0] axis[4:3]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [95:0]  m_axis_tdata_o,  // out_x out_y out_z
  output logic [0:0]   m_axis_tuser_o   // bad_axis
);

  localparam int DW = vlt_pkg::DataW;
  localparam int F  = vlt_pkg::FracBits;
  localparam int PW = vlt_pkg::ProdW;
  localparam int SW = vlt_pkg::SatW;
  localparam int ZW = vlt_pkg::ZW;
  localparam int CW = vlt_pkg::CW;

  // product pairs (row, column): three diagonal then upper off-diagonal
  localparam int PI_ [6] = '{0, 1, 2, 0, 0, 1};
  localparam int PJ_ [6] = '{0, 1, 2, 1, 2, 2};

  logic en;

  // stage 0: input register
  logic                  v0_q;
  vlt_pkg::item_t        it0_q;
  logic signed [18:0]    ang0_q;

  // stage 1: angle to Q30, wrap; multiplier left operands
  logic                  v1_q;
  vlt_pkg::item_t        it1_q, it1_d;
  logic signed [ZW-1:0]  z1_q, z1_d;

  // stage 2: fold into the right half-plane
  logic                  v2_q;
  vlt_pkg::item_t        it2_q;
  logic signed [ZW-1:0]  z2_d;
  logic signed [CW-1:0]  z2_q;
  logic                  flip2_q, flip2_d;

  logic                  cv;
  vlt_pkg::item_t        cit;
  logic signed [CW-1:0]  cx, cy;
  logic                  cflip;

  // stage M1
  logic                  v3_q;
  vlt_pkg::item_t        it3_q;
  logic signed [DW-1:0]  cos3_q, sin3_q, cos3_d, sin3_d;
  logic signed [PW-1:0]  prod3_q [6];

  // stage M2
  logic                  v4_q, bad4_q, zero4_q, bad4_d, zero4_d;
  logic [2:0][DW-1:0]    p4_q;
  logic signed [DW-1:0]  mat4_q [3][3];
  logic signed [DW-1:0]  mat4_d [3][3];

  // stage V1
  logic                  v5_q, bad5_q, zero5_q;
  logic signed [PW-1:0]  pm5_q [3][3];

  // stage V2 (output)
  logic                  v6_q, bad6_q;
  logic signed [DW-1:0]  out6_q [3];
  logic signed [DW-1:0]  out6_d [3];

  assign en              = m_axis_tready_i || !v6_q;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= cv;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // stage 0
  always_ff @(posedge clk_i) begin
    if (en) begin
      it0_q.opcode <= s_axis_tuser_i[2:0];
      it0_q.axis   <= s_axis_tuser_i[4:3];
      it0_q.vec    <= s_axis_tdata_i[95:0];
      it0_q.par    <= s_axis_tdata_i[191:96];
      it0_q.lhs    <= s_axis_tdata_i[191:96];
      ang0_q       <= signed'(s_axis_tdata_i[210:192]);
    end
  end

  // stage 1
  always_comb begin
    logic signed [ZW-1:0] za;
    logic signed [SW-1:0] nn;
    za = ZW'(ang0_q) <<< vlt_pkg::CordicShift;
    if (za > vlt_pkg::Q30Pi) begin
      z1_d = za - vlt_pkg::Q30TwoPi;
    end else if (za < -vlt_pkg::Q30Pi) begin
      z1_d = za + vlt_pkg::Q30TwoPi;
    end else begin
      z1_d = za;
    end
    it1_d = it0_q;
    for (int i = 0; i < 3; i++) begin
      nn = SW'(signed'(it0_q.par[i]));
      if (it0_q.opcode == vlt_pkg::OP_REFL_PL) begin
        it1_d.lhs[i] = vlt_pkg::sat32(-(nn <<< 1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it1_q <= it1_d;
      z1_q  <= z1_d;
    end
  end

  // stage 2
  always_comb begin
    flip2_d = 1'b0;
    z2_d    = z1_q;
    if (z1_q > vlt_pkg::Q30HalfPi) begin
      z2_d    = z1_q - vlt_pkg::Q30Pi;
      flip2_d = 1'b1;
    end else if (z1_q < -vlt_pkg::Q30HalfPi) begin
      z2_d    = z1_q + vlt_pkg::Q30Pi;
      flip2_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it2_q   <= it1_q;
      z2_q    <= z2_d[CW-1:0];
      flip2_q <= flip2_d;
    end
  end

  vlt_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .item_i  (it2_q),
    .z_i     (z2_q),
    .flip_i  (flip2_q),
    .valid_o (cv),
    .item_o  (cit),
    .x_o     (cx),
    .y_o     (cy),
    .flip_o  (cflip)
  );

  // stage M1: sin/cos scaling and the n products
  always_comb begin
    logic signed [CW-1:0] xf, yf, xs, ys;
    xf = cflip ? -cx : cx;
    yf = cflip ? -cy : cy;
    xs = xf >>> vlt_pkg::CordicShift;
    ys = yf >>> vlt_pkg::CordicShift;
    cos3_d = xs[DW-1:0];
    sin3_d = ys[DW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it3_q  <= cit;
      cos3_q <= cos3_d;
      sin3_q <= sin3_d;
      for (int k = 0; k < 6; k++) begin
        prod3_q[k] <= PW'(signed'(cit.lhs[PI_[k]])) * PW'(signed'(cit.par[PJ_[k]]));
      end
    end
  end

  // stage M2: matrix assembly
  always_comb begin
    logic signed [SW-1:0] fm  [6];
    logic signed [SW-1:0] one;
    logic signed [DW-1:0] ent [6];
    one = SW'(vlt_pkg::OneQ);
    for (int k = 0; k < 6; k++) begin
      fm[k] = SW'(signed'(prod3_q[k][PW-1:F]));
      if (it3_q.opcode == vlt_pkg::OP_PROJECT) begin
        ent[k] = (k < 3) ? vlt_pkg::sat32(one - fm[k]) : vlt_pkg::sat32(-fm[k]);
      end else begin
        ent[k] = (k < 3) ? vlt_pkg::sat32(one + fm[k]) : vlt_pkg::sat32(fm[k]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mat4_d[i][j] = (i == j) ? vlt_pkg::OneQ : '0;
      end
    end
    bad4_d  = 1'b0;
    zero4_d = 1'b0;
    case (it3_q.opcode)
      vlt_pkg::OP_ROTATE: begin
        case (it3_q.axis)
          vlt_pkg::AXIS_X: begin
            mat4_d[1][1] = cos3_q;  mat4_d[1][2] = sin3_q;
            mat4_d[2][1] = -sin3_q; mat4_d[2][2] = cos3_q;
          end
          vlt_pkg::AXIS_Y: begin
            mat4_d[0][0] = cos3_q;  mat4_d[0][2] = -sin3_q;
            mat4_d[2][0] = sin3_q;  mat4_d[2][2] = cos3_q;
          end
          vlt_pkg::AXIS_Z: begin
            mat4_d[0][0] = cos3_q;  mat4_d[0][1] = sin3_q;
            mat4_d[1][0] = -sin3_q; mat4_d[1][1] = cos3_q;
          end
          default: bad4_d = 1'b1;
        endcase
      end
      vlt_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          mat4_d[i][i] = signed'(it3_q.par[i]);
        end
      end
      vlt_pkg::OP_PROJECT, vlt_pkg::OP_REFL_PL: begin
        for (int k = 0; k < 6; k++) begin
          mat4_d[PI_[k]][PJ_[k]] = ent[k];
          mat4_d[PJ_[k]][PI_[k]] = ent[k];
        end
      end
      vlt_pkg::OP_REFL_AX: begin
        case (it3_q.axis)
          vlt_pkg::AXIS_X: mat4_d[0][0] = -vlt_pkg::OneQ;
          vlt_pkg::AXIS_Y: mat4_d[1][1] = -vlt_pkg::OneQ;
          vlt_pkg::AXIS_Z: mat4_d[2][2] = -vlt_pkg::OneQ;
          default:         bad4_d = 1'b1;
        endcase
      end
      vlt_pkg::OP_SHEAR: begin
        case (it3_q.axis)
          vlt_pkg::AXIS_X: begin
            mat4_d[0][1] = signed'(it3_q.par[0]); mat4_d[0][2] = signed'(it3_q.par[1]);
          end
          vlt_pkg::AXIS_Y: begin
            mat4_d[1][0] = signed'(it3_q.par[0]); mat4_d[1][2] = signed'(it3_q.par[1]);
          end
          vlt_pkg::AXIS_Z: begin
            mat4_d[2][0] = signed'(it3_q.par[0]); mat4_d[2][1] = signed'(it3_q.par[1]);
          end
          default: bad4_d = 1'b1;
        endcase
      end
      default: zero4_d = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_q    <= it3_q.vec;
      mat4_q  <= mat4_d;
      bad4_q  <= bad4_d;
      zero4_q <= zero4_d | bad4_d;
    end
  end

  // stage V1: vector times matrix products
  always_ff @(posedge clk_i) begin
    if (en) begin
      bad5_q  <= bad4_q;
      zero5_q <= zero4_q;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pm5_q[i][j] <= PW'(signed'(p4_q[i])) * PW'(mat4_q[i][j]);
        end
      end
    end
  end

  // stage V2: column sums and saturation
  always_comb begin
    logic signed [SW-1:0] acc;
    for (int j = 0; j < 3; j++) begin
      acc = '0;
      for (int i = 0; i < 3; i++) begin
        acc = acc + SW'(signed'(pm5_q[i][j][PW-1:F]));
      end
      out6_d[j] = zero5_q ? '0 : vlt_pkg::sat32(acc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out6_q <= out6_d;
      bad6_q <= bad5_q;
    end
  end

  assign m_axis_tvalid_o = v6_q;
  assign m_axis_tdata_o  = {out6_q[2], out6_q[1], out6_q[0]};
  assign m_axis_tuser_o  = bad6_q;

endmodule

/* tb/sv/tb.sv */
// tb: self-checking bench for vector_linear_3d_transform (stream in, stream out).
// Depends on vlt_pkg and the DUT; holds its own fixed-point transform predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 17;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1400;

  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
    logic               bad;
  } vec_out_t;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> vlt_pkg::FracBits;
  endfunction

  function automatic void sin_cos_q(input longint ang, output longint sn, output longint cs);
    longint z, x, y, nx;
    bit flip;
    z = ang * (64'sd1 <<< (30 - vlt_pkg::FracBits));
    x = 64'sd652032874;
    y = 0;
    flip = 0;
    z = z % 64'sd6746518852;
    if (z > 64'sd3373259426) z -= 64'sd6746518852;
    if (z < -64'sd3373259426) z += 64'sd6746518852;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      flip = 1;
    end
    for (int i = 0; i < vlt_pkg::CordicSteps; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(vlt_pkg::AtanQ30[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(vlt_pkg::AtanQ30[i]);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = x >>> (30 - vlt_pkg::FracBits);
    sn = y >>> (30 - vlt_pkg::FracBits);
  endfunction

  function automatic vec_out_t transform_vec(logic [2:0] op, logic [1:0] ax,
                                             logic [215:0] d);
    longint one, p[3], n[3], m[3][3], s, c, a[3], r;
    bit bad, ok;
    vec_out_t res;
    one = 64'sd1 <<< vlt_pkg::FracBits;
    bad = 0;
    ok = 1;
    for (int i = 0; i < 3; i++) begin
      p[i] = longint'($signed(d[32*i +: 32]));
      n[i] = longint'($signed(d[96 + 32*i +: 32]));
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) m[i][j] = (i == j) ? one : 0;
    case (op)
      vlt_pkg::OP_ROTATE: begin
        sin_cos_q(longint'($signed(d[210:192])), s, c);
        if (ax == vlt_pkg::AXIS_X) begin
          m[1][1] = c; m[1][2] = s; m[2][1] = -s; m[2][2] = c;
        end else if (ax == vlt_pkg::AXIS_Y) begin
          m[0][0] = c; m[0][2] = -s; m[2][0] = s; m[2][2] = c;
        end else if (ax == vlt_pkg::AXIS_Z) begin
          m[0][0] = c; m[0][1] = s; m[1][0] = -s; m[1][1] = c;
        end else bad = 1;
      end
      vlt_pkg::OP_SCALE: for (int i = 0; i < 3; i++) m[i][i] = n[i];
      vlt_pkg::OP_PROJECT:
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            m[i][j] = (i == j) ? clip32(one - qmul(n[i], n[i])) : clip32(-qmul(n[i], n[j]));
      vlt_pkg::OP_REFL_AX: begin
        if (ax != vlt_pkg::AXIS_NONE) m[ax-1][ax-1] = -one;
        else bad = 1;
      end
      vlt_pkg::OP_REFL_PL: begin
        for (int i = 0; i < 3; i++) a[i] = clip32(-2 * n[i]);
        for (int i = 0; i < 3; i++) begin
          m[i][i] = clip32(one + qmul(a[i], n[i]));
          for (int j = i + 1; j < 3; j++) begin
            m[i][j] = clip32(qmul(a[i], n[j]));
            m[j][i] = m[i][j];
          end
        end
      end
      vlt_pkg::OP_SHEAR: begin
        if (ax == vlt_pkg::AXIS_X) begin
          m[0][1] = n[0]; m[0][2] = n[1];
        end else if (ax == vlt_pkg::AXIS_Y) begin
          m[1][0] = n[0]; m[1][2] = n[1];
        end else if (ax == vlt_pkg::AXIS_Z) begin
          m[2][0] = n[0]; m[2][1] = n[1];
        end else bad = 1;
      end
      default: ok = 0;
    endcase
    for (int j = 0; j < 3; j++) begin
      r = 0;
      if (ok && !bad) begin
        for (int i = 0; i < 3; i++) r += qmul(p[i], m[i][j]);
        r = clip32(r);
      end
      if (j == 0) res.x = r[31:0];
      else if (j == 1) res.y = r[31:0];
      else res.z = r[31:0];
    end
    res.bad = bad;
    return res;
  endfunction

  class transform_scoreboard;
    vec_out_t pending[$];
    int errors;

    function void note_beat(logic [2:0] op, logic [1:0] ax, logic [215:0] d);
      pending.push_back(transform_vec(op, ax, d));
    endfunction

    function void check_beat(logic [95:0] d, logic bad);
      vec_out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected output beat %h bad=%b", $time, d, bad);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.x) begin
        $display("%0t: out_x expected %h actual %h", $time, e.x, d[31:0]);
        errors++;
      end
      if (d[63:32] !== e.y) begin
        $display("%0t: out_y expected %h actual %h", $time, e.y, d[63:32]);
        errors++;
      end
      if (d[95:64] !== e.z) begin
        $display("%0t: out_z expected %h actual %h", $time, e.z, d[95:64]);
        errors++;
      end
      if (bad !== e.bad) begin
        $display("%0t: bad_axis expected %b actual %b", $time, e.bad, bad);
        errors++;
      end
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid_i = 0;
  logic         s_axis_tready_o;
  logic [215:0] s_axis_tdata_i = '0;
  logic [4:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 0;
  logic [95:0]  m_axis_tdata_o;
  logic [0:0]   m_axis_tuser_o;

  vector_linear_3d_transform DUT (.*);

  always #5 clk_i = ~clk_i;

  transform_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 0;
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        sb.note_beat(s_axis_tuser_i[2:0], s_axis_tuser_i[4:3], s_axis_tdata_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_beat(m_axis_tdata_o, m_axis_tuser_o[0]);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
      m_axis_tready_i <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0001_0000;
      3: return 32'hFFFF_0000;
      4: return $urandom_range(32'h0002_0000) - 32'h0001_0000;
      5: return $urandom_range(32'h0100_0000) - 32'h0080_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(logic [2:0] op, logic [1:0] ax, logic [31:0] w[6],
                           logic [18:0] ang);
    logic [215:0] d;
    d = '0;
    for (int i = 0; i < 6; i++) d[32*i +: 32] = w[i];
    d[210:192] = ang;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tdata_i <= d;
    s_axis_tuser_i <= {ax, op};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic send_random();
    logic [31:0] w[6];
    logic [18:0] ang;
    for (int i = 0; i < 6; i++) w[i] = pick_word();
    ang = 19'($signed($urandom_range(411774)) - 205887);
    send_beat(3'($urandom_range(7)), 2'($urandom_range(3)), w, ang);
  endtask

  initial begin
    logic [31:0] w[6];
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_idle_pct = 26;
    recv_idle_pct = 84;
    // directed: every opcode with axes NONE and X, ROTATE with every axis, extreme fields and angles
    for (int op = 0; op < 8; op++) begin
      for (int ax = 0; ax < 4; ax++) begin
        if (op != vlt_pkg::OP_ROTATE && ax > 1) continue;
        for (int i = 0; i < 6; i++)
          w[i] = (ax[0]) ? 32'h7FFF_FFFF : ((i % 2) ? 32'h8000_0000 : 32'h0001_8000);
        send_beat(3'(op), 2'(ax), w,
                  (op == vlt_pkg::OP_ROTATE && ax == vlt_pkg::AXIS_Z) ?
                  19'sd205887 : -19'sd205887);
      end
    end
    for (int i = 0; i < 6; i++) w[i] = 32'h0001_0000;
    send_beat(vlt_pkg::OP_ROTATE, vlt_pkg::AXIS_Z, w, 19'sd102944);
    send_beat(vlt_pkg::OP_ROTATE, vlt_pkg::AXIS_Y, w, -19'sd102944);
    send_beat(vlt_pkg::OP_ROTATE, vlt_pkg::AXIS_X, w, 19'sd0);
    send_beat(vlt_pkg::OP_REFL_AX, vlt_pkg::AXIS_Z, w, 19'sd0);
    send_beat(vlt_pkg::OP_SHEAR, vlt_pkg::AXIS_Z, w, 19'sd0);
    send_beat(vlt_pkg::OP_SHEAR, vlt_pkg::AXIS_Y, w, 19'sd0);

    for (int k = 0; k < N_RANDOM / 3; k++) send_random();
    // long receiver hold-off so the pipeline fills and input stalls
    recv_hold = 1;
    fork
      begin
        repeat (200) @(posedge clk_i);
        recv_hold = 0;
      end
    join_none
    send_idle_pct = 84;
    recv_idle_pct = 26;
    for (int k = 0; k < N_RANDOM / 3; k++) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int k = 0; k < N_RANDOM / 3; k++) send_random();
    s_axis_tvalid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
